// ===== rtl/csvt_pkg.sv =====
// csvt_pkg: types, event codes and constants shared by the csv event tokenizer
// used by csvt_step, csv_event_tokenizer and csvt_checker; no dependencies
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int unsigned EvMax = 4;
  localparam int unsigned EvCntW = 3;

  localparam logic [7:0] QuoteReset = 8'd34;
  localparam logic [7:0] DelimReset = 8'd44;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  // configuration register indexes
  localparam logic CfgQuote = 1'b0;
  localparam logic CfgDelim = 1'b1;

  typedef enum logic [3:0] {
    EV_HDR_START  = 4'd0,
    EV_HDR_END    = 4'd1,
    EV_BODY_START = 4'd2,
    EV_REC_START  = 4'd3,
    EV_VALUE      = 4'd4,
    EV_COL_END    = 4'd5,
    EV_FLD_END    = 4'd6,
    EV_REC_END    = 4'd7,
    EV_BODY_END   = 4'd8
  } event_e;

  typedef enum logic [2:0] {
    PH_HDR_START = 3'd0,
    PH_COL_START = 3'd1,
    PH_COL       = 3'd2,
    PH_HDR_END   = 3'd3,
    PH_REC_START = 3'd4,
    PH_FLD_START = 3'd5,
    PH_FLD       = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [7:0] value_byte;
    logic       was_quoted;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    phase_e phase;
    logic   value_quoted;
    logic   inside_quotes;
    logic   ignore_rest;
    logic   quote_pending;
  } parse_state_t;

  typedef struct packed {
    event_e     kind;
    logic [7:0] vbyte;
    logic       quoted;
  } ev_t;

  typedef struct packed {
    ev_t [EvMax-1:0]   evs;
    logic [EvCntW-1:0] cnt;
  } step_res_t;

  function automatic ev_t mk_ev(event_e k, logic [7:0] b, logic q);
    ev_t e;
    e.kind = k;
    e.vbyte = b;
    e.quoted = q;
    return e;
  endfunction

endpackage

// ===== rtl/csvt_step.sv =====
// csvt_step: next parser state and up to four events for one input beat
// depends on csvt_pkg
`timescale 1ns / 1ps

module csvt_step (
  input  csvt_pkg::parse_state_t state_i,
  input  csvt_pkg::in_t          in_i,
  input  logic [7:0]             quote_char_i,
  input  logic [7:0]             delim_char_i,
  output csvt_pkg::parse_state_t state_o,
  output csvt_pkg::step_res_t    res_o
);

  csvt_pkg::parse_state_t st;
  csvt_pkg::ev_t [csvt_pkg::EvMax-1:0] evs;
  logic [csvt_pkg::EvCntW-1:0] n;
  logic [7:0] ch;
  logic line_end, is_quote, is_delim;
  logic hdr, do_start, do_value, cont;

  assign ch = in_i.in_byte;
  assign line_end = (ch == csvt_pkg::ChLf) || (ch == csvt_pkg::ChCr);
  assign is_quote = (ch == quote_char_i);
  assign is_delim = (ch == delim_char_i);

  always_comb begin
    st = state_i;
    evs = '0;
    n = '0;
    hdr = 1'b0;
    do_start = 1'b0;
    do_value = 1'b0;
    cont = 1'b1;

    if (in_i.end_of_input) begin
      unique case (state_i.phase)
        csvt_pkg::PH_COL_START, csvt_pkg::PH_COL: begin
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_COL_END, 8'd0,
              (state_i.phase == csvt_pkg::PH_COL) && state_i.value_quoted);
          n = n + 3'd1;
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_HDR_END, 8'd0, 1'b0);
          n = n + 3'd1;
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_BODY_START, 8'd0, 1'b0);
          n = n + 3'd1;
        end
        csvt_pkg::PH_HDR_END: begin
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_BODY_START, 8'd0, 1'b0);
          n = n + 3'd1;
        end
        csvt_pkg::PH_REC_START: begin
        end
        csvt_pkg::PH_FLD_START, csvt_pkg::PH_FLD: begin
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_FLD_END, 8'd0,
              (state_i.phase == csvt_pkg::PH_FLD) && state_i.value_quoted);
          n = n + 3'd1;
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_REC_END, 8'd0, 1'b0);
          n = n + 3'd1;
        end
        default: begin
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_HDR_START, 8'd0, 1'b0);
          n = n + 3'd1;
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_HDR_END, 8'd0, 1'b0);
          n = n + 3'd1;
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_BODY_START, 8'd0, 1'b0);
          n = n + 3'd1;
        end
      endcase
      evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_BODY_END, 8'd0, 1'b0);
      n = n + 3'd1;
      st = '{phase: csvt_pkg::PH_HDR_START, default: 1'b0};
    end else begin
      unique case (state_i.phase)
        csvt_pkg::PH_COL_START: begin
          hdr = 1'b1;
          do_start = 1'b1;
        end
        csvt_pkg::PH_COL: begin
          hdr = 1'b1;
          do_value = 1'b1;
        end
        csvt_pkg::PH_HDR_END: begin
          evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_BODY_START, 8'd0, 1'b0);
          n = n + 3'd1;
          st.phase = csvt_pkg::PH_REC_START;
          if (!line_end) begin
            evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_REC_START, 8'd0, 1'b0);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        csvt_pkg::PH_REC_START: begin
          if (!line_end) begin
            evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_REC_START, 8'd0, 1'b0);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        csvt_pkg::PH_FLD_START: begin
          do_start = 1'b1;
        end
        csvt_pkg::PH_FLD: begin
          do_value = 1'b1;
        end
        default: begin
          // still waiting for the header; blank lines skipped
          if (!line_end) begin
            evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_HDR_START, 8'd0, 1'b0);
            n = n + 3'd1;
            hdr = 1'b1;
            do_start = 1'b1;
          end
        end
      endcase

      // first byte of a value
      if (do_start) begin
        st.value_quoted = is_quote;
        st.phase = hdr ? csvt_pkg::PH_COL : csvt_pkg::PH_FLD;
        if (is_quote) begin
          st.inside_quotes = 1'b1;
        end else begin
          do_value = 1'b1;
        end
      end

      // byte inside a value
      if (do_value) begin
        if (st.quote_pending) begin
          st.quote_pending = 1'b0;
          if (is_quote) begin
            evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_VALUE, ch, 1'b0);
            n = n + 3'd1;
            cont = 1'b0;
          end else begin
            st.inside_quotes = 1'b0;
            st.ignore_rest = 1'b1;
          end
        end else if (st.inside_quotes) begin
          if (is_quote) begin
            st.quote_pending = 1'b1;
          end else begin
            evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_VALUE, ch, 1'b0);
            n = n + 3'd1;
          end
          cont = 1'b0;
        end

        if (cont) begin
          priority if (is_delim) begin
            evs[n[1:0]] = csvt_pkg::mk_ev(
                hdr ? csvt_pkg::EV_COL_END : csvt_pkg::EV_FLD_END, 8'd0, st.value_quoted);
            n = n + 3'd1;
            st.ignore_rest = 1'b0;
            st.phase = hdr ? csvt_pkg::PH_COL_START : csvt_pkg::PH_FLD_START;
          end else if (line_end) begin
            evs[n[1:0]] = csvt_pkg::mk_ev(
                hdr ? csvt_pkg::EV_COL_END : csvt_pkg::EV_FLD_END, 8'd0, st.value_quoted);
            n = n + 3'd1;
            st.ignore_rest = 1'b0;
            evs[n[1:0]] = csvt_pkg::mk_ev(
                hdr ? csvt_pkg::EV_HDR_END : csvt_pkg::EV_REC_END, 8'd0, 1'b0);
            n = n + 3'd1;
            st.phase = hdr ? csvt_pkg::PH_HDR_END : csvt_pkg::PH_REC_START;
          end else begin
            if (!st.ignore_rest) begin
              evs[n[1:0]] = csvt_pkg::mk_ev(csvt_pkg::EV_VALUE, ch, 1'b0);
              n = n + 3'd1;
            end
          end
        end
      end
    end
  end

  assign state_o = st;
  assign res_o.evs = evs;
  assign res_o.cnt = n;

endmodule

// ===== rtl/csv_event_tokenizer.sv =====
// csv_event_tokenizer: streaming csv tokenizer, one text byte in, event beats out
// depends on csvt_pkg and csvt_step
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | csvt_pkg::in_t  (byte, end flag)
//  out     | output    | out_valid_o / out_stall_i | csvt_pkg::out_t (one event)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  one input beat is parsed in the cycle it is accepted; its 0..4 events land in a
//  four-entry event register and leave one per cycle while out_stall_i is low, so a
//  byte with several events holds the output until all have left and stalls the input
//  until its last event leaves (bytes with one or no event stream at one per cycle
//  while the output does not stall); the input is taken again in the same cycle the
//  last event of the previous byte leaves, so no bubble between bytes
//  reset clears parser state and the event count and read pointer, and sets the config registers to their defaults

module csv_event_tokenizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  // byte input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  csvt_pkg::in_t    in_data_i,
  // event output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output csvt_pkg::out_t   out_data_o,
  // config writes
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [7:0]       cfg_data_i
);

  // config registers
  logic [7:0] quote_q, delim_q;

  // parser state
  csvt_pkg::parse_state_t state_q, state_d;
  csvt_pkg::step_res_t    res;

  // event register: entries, count of valid entries, read pointer
  csvt_pkg::ev_t [csvt_pkg::EvMax-1:0] evs_q;
  logic [csvt_pkg::EvCntW-1:0] cnt_q;
  logic [1:0]                  rd_q;

  logic in_acc, out_acc, out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= csvt_pkg::QuoteReset;
      delim_q <= csvt_pkg::DelimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csvt_pkg::CfgQuote: quote_q <= cfg_data_i;
        csvt_pkg::CfgDelim: delim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csvt_step u_step (
    .state_i      (state_q),
    .in_i         (in_data_i),
    .quote_char_i (quote_q),
    .delim_char_i (delim_q),
    .state_o      (state_d),
    .res_o        (res)
  );

  // last event of the current run sits at the read pointer
  assign out_last = ({1'b0, rd_q} == (cnt_q - 3'd1));
  assign out_valid_o = (cnt_q != '0);
  assign out_acc = out_valid_o && !out_stall_i;

  // take a byte when the event register is empty or its final beat leaves now
  assign in_stall_o = out_valid_o && !(out_last && !out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: csvt_pkg::PH_HDR_START, default: 1'b0};
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (in_acc) begin
      // a new run replaces whatever just drained (or nothing, for a silent byte)
      cnt_q <= res.cnt;
      rd_q  <= '0;
    end else if (out_acc) begin
      if (out_last) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && (res.cnt != '0)) begin
      evs_q <= res.evs;
    end
  end

  assign out_data_o.event_kind  = evs_q[rd_q].kind;
  assign out_data_o.value_byte  = evs_q[rd_q].vbyte;
  assign out_data_o.was_quoted  = evs_q[rd_q].quoted;
  assign out_data_o.last_of_run = out_last;

endmodule

// ===== rtl/csvt_checker.sv =====
// csvt_props: port-level assertions for the csv event tokenizer, bound to the top
// depends on csvt_pkg and csv_event_tokenizer
`timescale 1ns / 1ps

module csvt_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input csvt_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input csvt_pkg::out_t out_data_o
);

  // stalled output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // end of input always yields at least body end
  a_eoi_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.end_of_input |=> out_valid_o)
    else $error("end of input produced no events");

  // no byte taken while a run still has beats behind the current one
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> in_stall_o)
    else $error("input taken in the middle of a run");

  // event codes stay in range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.event_kind <= csvt_pkg::EV_BODY_END)
    else $error("event kind out of range");

  // value byte is only carried on value events
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_kind != csvt_pkg::EV_VALUE)
      |-> out_data_o.value_byte == 8'd0)
    else $error("value byte set on a non-value event");

endmodule

bind csv_event_tokenizer csvt_props u_csvt_props (.*);

// ===== tb/csvt_checker.sv =====
// csvt_checker: watches the byte and event channels of csv_event_tokenizer, predicts the
// event beats of every accepted byte and compares them in order; depends on csvt_pkg
`timescale 1ns / 1ps

module csvt_checker
  import csvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_t       out_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         pending_o
);

  // parser copy
  phase_e     cur_phase;
  logic       val_quoted;
  logic       in_quotes;
  logic       skip_rest;
  logic       quote_pend;
  logic [7:0] quote_r;
  logic [7:0] delim_r;

  out_t run_evs[$];     // events of the byte being predicted
  out_t exp_events[$];  // events still owed by the block

  function automatic logic line_end(logic [7:0] ch);
    return ch == ChLf || ch == ChCr;
  endfunction

  task automatic add_ev(event_e k, logic [7:0] b, logic q);
    out_t e;
    e.event_kind = k;
    e.value_byte = b;
    e.was_quoted = q;
    e.last_of_run = 1'b0;
    run_evs.push_back(e);
  endtask

  task automatic value_char(logic hdr, logic [7:0] ch);
    if (quote_pend) begin
      quote_pend = 1'b0;
      // doubled quote is one literal quote
      if (ch == quote_r) begin
        add_ev(EV_VALUE, ch, 1'b0);
        return;
      end
      in_quotes = 1'b0;
      skip_rest = 1'b1;
    end else if (in_quotes) begin
      if (ch == quote_r) quote_pend = 1'b1;
      else add_ev(EV_VALUE, ch, 1'b0);
      return;
    end
    if (ch == delim_r) begin
      add_ev(hdr ? EV_COL_END : EV_FLD_END, 8'h00, val_quoted);
      skip_rest = 1'b0;
      cur_phase = hdr ? PH_COL_START : PH_FLD_START;
      return;
    end
    if (line_end(ch)) begin
      add_ev(hdr ? EV_COL_END : EV_FLD_END, 8'h00, val_quoted);
      skip_rest = 1'b0;
      if (hdr) begin
        add_ev(EV_HDR_END, 8'h00, 1'b0);
        cur_phase = PH_HDR_END;
      end else begin
        add_ev(EV_REC_END, 8'h00, 1'b0);
        cur_phase = PH_REC_START;
      end
      return;
    end
    if (!skip_rest) add_ev(EV_VALUE, ch, 1'b0);
  endtask

  task automatic start_value(logic hdr, logic [7:0] ch);
    val_quoted = (ch == quote_r);
    cur_phase = hdr ? PH_COL : PH_FLD;
    if (val_quoted) in_quotes = 1'b1;
    else value_char(hdr, ch);
  endtask

  task automatic clear_parser();
    cur_phase = PH_HDR_START;
    val_quoted = 1'b0;
    in_quotes = 1'b0;
    skip_rest = 1'b0;
    quote_pend = 1'b0;
  endtask

  task automatic predict_byte(in_t b);
    out_t e;
    run_evs.delete();
    if (b.end_of_input) begin
      case (cur_phase)
        PH_COL_START, PH_COL: begin
          add_ev(EV_COL_END, 8'h00, (cur_phase == PH_COL) ? val_quoted : 1'b0);
          add_ev(EV_HDR_END, 8'h00, 1'b0);
          add_ev(EV_BODY_START, 8'h00, 1'b0);
        end
        PH_HDR_END: add_ev(EV_BODY_START, 8'h00, 1'b0);
        PH_REC_START: ;
        PH_FLD_START, PH_FLD: begin
          add_ev(EV_FLD_END, 8'h00, (cur_phase == PH_FLD) ? val_quoted : 1'b0);
          add_ev(EV_REC_END, 8'h00, 1'b0);
        end
        default: begin
          add_ev(EV_HDR_START, 8'h00, 1'b0);
          add_ev(EV_HDR_END, 8'h00, 1'b0);
          add_ev(EV_BODY_START, 8'h00, 1'b0);
        end
      endcase
      add_ev(EV_BODY_END, 8'h00, 1'b0);
      clear_parser();
    end else begin
      case (cur_phase)
        PH_COL_START: start_value(1'b1, b.in_byte);
        PH_COL:       value_char(1'b1, b.in_byte);
        PH_HDR_END: begin
          add_ev(EV_BODY_START, 8'h00, 1'b0);
          cur_phase = PH_REC_START;
          if (!line_end(b.in_byte)) begin
            add_ev(EV_REC_START, 8'h00, 1'b0);
            start_value(1'b0, b.in_byte);
          end
        end
        PH_REC_START: begin
          if (!line_end(b.in_byte)) begin
            add_ev(EV_REC_START, 8'h00, 1'b0);
            start_value(1'b0, b.in_byte);
          end
        end
        PH_FLD_START: start_value(1'b0, b.in_byte);
        PH_FLD:       value_char(1'b0, b.in_byte);
        default: begin
          if (!line_end(b.in_byte)) begin
            add_ev(EV_HDR_START, 8'h00, 1'b0);
            start_value(1'b1, b.in_byte);
          end
        end
      endcase
    end
    foreach (run_evs[i]) begin
      e = run_evs[i];
      e.last_of_run = (i == run_evs.size() - 1);
      exp_events.push_back(e);
    end
  endtask

  task automatic field_check(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt_o++;
    end
  endtask

  task automatic check_event(out_t got);
    out_t want;
    if (exp_events.size() == 0) begin
      $error("event beat with nothing expected: kind %0d byte %0h",
             got.event_kind, got.value_byte);
      fail_cnt_o++;
    end else begin
      want = exp_events.pop_front();
      field_check("event_kind", 8'(want.event_kind), 8'(got.event_kind));
      field_check("value_byte", want.value_byte, got.value_byte);
      field_check("was_quoted", 8'(want.was_quoted), 8'(got.was_quoted));
      field_check("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      quote_r = QuoteReset;
      delim_r = DelimReset;
      exp_events.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_event(out_data_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgQuote) quote_r = cfg_data_i;
        else delim_r = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) predict_byte(in_data_i);
      pending_o = exp_events.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for csv_event_tokenizer; feeds csv text beats under several
// quote/delimiter settings, checking is done by csvt_checker; depends on csvt_pkg
`timescale 1ns / 1ps

module tb;
  import csvt_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  // byte channel
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  in_t        byte_beat = '0;
  // event channel
  logic       ev_valid;
  logic       ev_stall = 1'b0;
  out_t       ev_beat;
  // config port
  logic       cfg_we = 1'b0;
  logic       cfg_idx = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  int fails;
  int pending;
  int items_sent = 0;

  // idle rates in percent, changed only between phases
  int send_idle_pct = 38;
  int recv_idle_pct = 46;

  // the generator's view of the current special bytes
  logic [7:0] quote_cur = QuoteReset;
  logic [7:0] delim_cur = DelimReset;

  csv_event_tokenizer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (byte_valid),
    .in_stall_o  (byte_stall),
    .in_data_i   (byte_beat),
    .out_valid_o (ev_valid),
    .out_stall_i (ev_stall),
    .out_data_o  (ev_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  csvt_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (byte_valid),
    .in_stall_i  (byte_stall),
    .in_data_i   (byte_beat),
    .out_valid_i (ev_valid),
    .out_stall_i (ev_stall),
    .out_data_i  (ev_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fails),
    .pending_o   (pending)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    ev_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one byte beat: random gap first, then hold the beat until it is taken;
  // valid stays high afterwards so back-to-back beats have no bubble
  task automatic send_beat(logic [7:0] b, logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat <= {b, eoi};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // drop valid and hold off until every owed event beat is out, then let the
  // event register settle (bytes with no event leave nothing to count on)
  task automatic wait_idle();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (EvMax + 2) @(negedge clk);
  endtask

  // both registers, only ever called while the block is idle
  task automatic set_config(logic [7:0] q, logic [7:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= CfgQuote;
    cfg_data <= q;
    @(negedge clk);
    cfg_idx <= CfgDelim;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    quote_cur = q;
    delim_cur = d;
    @(negedge clk);
  endtask

  // a value byte that is none of quote, delimiter or line end
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == quote_cur || c == delim_cur || c == ChCr || c == ChLf);
    return c;
  endfunction

  task automatic send_line_end();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0) send_beat(ChLf, 1'b0);
    else if (pick == 1) send_beat(ChCr, 1'b0);
    else begin
      send_beat(ChCr, 1'b0);
      send_beat(ChLf, 1'b0);
    end
  endtask

  // empty, plain or quoted value; quoted ones may hold doubled quotes, junk after
  // the closing quote, or never close at all
  task automatic send_value();
    int kind;
    kind = $urandom_range(2);
    if (kind == 1) begin
      repeat ($urandom_range(1, 4)) send_beat(plain_char(), 1'b0);
    end else if (kind == 2) begin
      send_beat(quote_cur, 1'b0);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(3) == 0) begin
          send_beat(quote_cur, 1'b0);
          send_beat(quote_cur, 1'b0);
        end else begin
          send_beat(plain_char(), 1'b0);
        end
      end
      if ($urandom_range(5) != 0) begin
        send_beat(quote_cur, 1'b0);
        if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) send_beat(plain_char(), 1'b0);
      end
    end
  endtask

  task automatic send_line(int ncols, logic term);
    for (int c = 0; c < ncols; c++) begin
      send_value();
      if (c < ncols - 1) send_beat(delim_cur, 1'b0);
    end
    if (term) send_line_end();
  endtask

  // one document closed by end of input; mostly well-formed csv, some raw noise
  task automatic send_doc();
    int ncols;
    int nrecs;
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 12))
        send_beat(8'($urandom_range(255)), $urandom_range(15) == 0);
    end else begin
      repeat ($urandom_range(0, 2)) send_line_end();
      ncols = $urandom_range(1, 3);
      nrecs = $urandom_range(0, 3);
      send_line(ncols, (nrecs > 0) || ($urandom_range(2) != 0));
      for (int r = 0; r < nrecs; r++) begin
        // blank line between records
        if ($urandom_range(3) == 0) send_line_end();
        send_line(($urandom_range(3) == 0) ? $urandom_range(1, 3) : ncols,
                  (r < nrecs - 1) || ($urandom_range(2) != 0));
      end
    end
    // occasionally let the output run dry mid-document
    if ($urandom_range(9) == 0) wait_idle();
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_phase(logic [7:0] q, logic [7:0] d, int sp, int rp);
    int stop_at;
    wait_idle();
    set_config(q, d);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    stop_at = items_sent + 32;
    while (items_sent < stop_at) send_doc();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_config(QuoteReset, DelimReset);

    // empty input
    send_beat(8'h00, 1'b1);
    // leading blank lines, doubled quote, junk after a closing quote, then a
    // body field of extreme bytes left open at end of input
    send_text("\r\na,\"b\"\"\"q\r\n");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    // quote just seen at end of input, with the output drained first
    send_text("\"k\"");
    wait_idle();
    send_beat(8'h00, 1'b1);
    // header line ended, no body
    send_text("h\n");
    send_beat(8'h00, 1'b1);
    // trailing delimiter leaves an empty column open
    send_text("a,");
    send_beat(8'h00, 1'b1);

    // receiver idles more first, then the sender, then neither
    run_phase(QuoteReset, DelimReset, 38, 46);
    run_phase(8'h00, 8'hFF, 38, 46);
    run_phase(8'hFF, 8'h00, 46, 38);
    run_phase(DelimReset, DelimReset, 46, 38);   // quote equal to delimiter
    run_phase(QuoteReset, ChCr, 0, 0);           // delimiter equal to a line end
    run_phase(ChLf, 8'h3B, 0, 0);                // quote equal to a line end
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 0, 0);

    wait_idle();
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
